/* design/ist_pkg.sv */
// ----------------------------------------------------------------------------
// ist_pkg
// Shared constants and types for the integer set table: store size, field
// widths, operation codes and the control bundle of the shared scan unit.
// ----------------------------------------------------------------------------
package ist_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 2;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    // Operation codes. Every other code behaves as a membership test.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;

    // Control of the scan unit in the current cycle.
    typedef struct packed {
        logic clear;     // Start a new minimum/maximum reduction.
        logic step;      // Present one element to the unit.
        logic elem_vld;  // The element belongs to the set.
        logic excl_eq;   // Leave the element out when it equals the key.
    } scan_ctrl_t;

endpackage

/* design/ist_slot_ram.sv */
// ----------------------------------------------------------------------------
// ist_slot_ram
// Simple single-port-write, single-port-read memory with registered read
// data. Holds the values of the set slots.
// ----------------------------------------------------------------------------
module ist_slot_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/ist_scan_unit.sv */
// ----------------------------------------------------------------------------
// ist_scan_unit
// Shared compare unit. Each step compares one element against the key for
// equality and against the running minimum and maximum.
// ----------------------------------------------------------------------------
module ist_scan_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ist_pkg::scan_ctrl_t              ctrl,
    input  logic signed [ist_pkg::DATA_W-1:0] elem,
    input  logic signed [ist_pkg::DATA_W-1:0] key,
    output logic                             eq,
    output logic                             any,
    output logic signed [ist_pkg::DATA_W-1:0] lo,
    output logic signed [ist_pkg::DATA_W-1:0] hi
);
    import ist_pkg::*;

    logic                     any_reg;
    logic                     any_next;
    logic signed [DATA_W-1:0] lo_reg;
    logic signed [DATA_W-1:0] lo_next;
    logic signed [DATA_W-1:0] hi_reg;
    logic signed [DATA_W-1:0] hi_next;
    logic                     take;

    assign eq   = (elem == key);
    assign take = ctrl.step && ctrl.elem_vld && !(ctrl.excl_eq && eq);

    always_comb
    begin
        any_next = any_reg;
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        if (ctrl.clear)
        begin
            any_next = 1'b0;
        end
        else if (take)
        begin
            any_next = 1'b1;
            if (!any_reg)
            begin
                lo_next = elem;
                hi_next = elem;
            end
            else
            begin
                if (elem < lo_reg)
                begin
                    lo_next = elem;
                end
                if (elem > hi_reg)
                begin
                    hi_next = elem;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_reg <= 1'b0;
        end
        else
        begin
            any_reg <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    assign any = any_reg;
    assign lo  = lo_reg;
    assign hi  = hi_reg;

endmodule

/* design/integer_set_table_top.sv */
// ----------------------------------------------------------------------------
// integer_set_table_top
// Bounded set of distinct signed 32-bit integers with insert, remove and
// membership test, reporting hit, count, empty flag, minimum and maximum.
// ----------------------------------------------------------------------------
// Usage:
// A transaction is issued by holding start high with op and value valid; it
// is accepted at the rising edge where start is high and busy is low.
// op 0 inserts, op 1 removes, any other code only tests membership.
// The block then walks all CAPACITY slots through one shared compare unit,
// one slot per cycle, finding the match, the first free slot and the minimum
// and maximum of the remaining elements. The data of the last slot read
// arrives in the drain state, then the merge state applies the update and
// folds the operand into the minimum and maximum when it stays in the set.
// The result appears in the response state, after the drain and merge
// states, with done high for exactly one cycle. busy falls in that result
// cycle, so a new transaction can be accepted at the edge that ends it; no
// other transaction is taken while one is in progress, as the slot scan
// goes through the single read port of the slot memory.
// The receiver cannot stall: each result is valid only while done is high.
// Reset empties the set by clearing the occupancy bits and the count; slot
// values are not cleared, since a slot value is only used while occupied.
// ----------------------------------------------------------------------------
module integer_set_table_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [ist_pkg::OP_W-1:0]           op,
    input  logic signed [ist_pkg::DATA_W-1:0]  value,
    output logic                               done,
    output logic                               hit,
    output logic                               full_reject,
    output logic [ist_pkg::COUNT_W-1:0]        count,
    output logic                               is_empty,
    output logic signed [ist_pkg::DATA_W-1:0]  min_value,
    output logic signed [ist_pkg::DATA_W-1:0]  max_value
);
    import ist_pkg::*;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_MERGE = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    state_t                   state_reg,     state_next;
    logic [IDX_W-1:0]         rd_idx_reg,    rd_idx_next;
    logic                     proc_vld_reg,  proc_vld_next;
    logic [IDX_W-1:0]         proc_idx_reg,  proc_idx_next;
    logic [OP_W-1:0]          op_reg,        op_next;
    logic signed [DATA_W-1:0] val_reg,       val_next;
    logic                     match_fnd_reg, match_fnd_next;
    logic [IDX_W-1:0]         match_idx_reg, match_idx_next;
    logic                     free_fnd_reg,  free_fnd_next;
    logic [IDX_W-1:0]         free_idx_reg,  free_idx_next;
    logic                     reject_reg,    reject_next;
    logic [CAPACITY-1:0]      used_reg,      used_next;
    logic [COUNT_W-1:0]       count_reg,     count_next;

    scan_ctrl_t               scan_ctrl;
    logic signed [DATA_W-1:0] scan_elem;
    logic                     scan_eq;
    logic                     scan_any;
    logic signed [DATA_W-1:0] scan_lo;
    logic signed [DATA_W-1:0] scan_hi;

    logic                     ram_we;
    logic [DATA_W-1:0]        ram_rdata;
    logic                     accept;
    logic                     keep_val;
    logic                     cur_used;

    assign accept   = start && !busy;
    assign cur_used = used_reg[proc_idx_reg];

    // The operand stays in the set after an insert that hit or found room,
    // and after a test that hit; a remove always takes it out.
    always_comb
    begin
        if (op_reg == OP_INSERT)
        begin
            keep_val = match_fnd_reg || free_fnd_reg;
        end
        else if (op_reg == OP_REMOVE)
        begin
            keep_val = 1'b0;
        end
        else
        begin
            keep_val = match_fnd_reg;
        end
    end

    // During the scan the unit sees memory data; in the merge cycle it sees
    // the operand itself.
    assign scan_elem = (state_reg == ST_MERGE) ? val_reg : $signed(ram_rdata);

    always_comb
    begin
        state_next     = state_reg;
        rd_idx_next    = rd_idx_reg;
        proc_vld_next  = (state_reg == ST_SCAN);
        proc_idx_next  = rd_idx_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        match_fnd_next = match_fnd_reg;
        match_idx_next = match_idx_reg;
        free_fnd_next  = free_fnd_reg;
        free_idx_next  = free_idx_reg;
        reject_next    = reject_reg;
        used_next      = used_reg;
        count_next     = count_reg;
        scan_ctrl      = '0;
        ram_we         = 1'b0;

        // Slot data arrives in the cycle after its read; process it here.
        if (proc_vld_reg)
        begin
            scan_ctrl.step     = 1'b1;
            scan_ctrl.elem_vld = cur_used;
            scan_ctrl.excl_eq  = 1'b1;
            if (cur_used && scan_eq && !match_fnd_reg)
            begin
                match_fnd_next = 1'b1;
                match_idx_next = proc_idx_reg;
            end
            if (!cur_used && !free_fnd_reg)
            begin
                free_fnd_next = 1'b1;
                free_idx_next = proc_idx_reg;
            end
        end

        case (state_reg)
            ST_IDLE, ST_RESP:
            begin
                if (accept)
                begin
                    op_next         = op;
                    val_next        = value;
                    rd_idx_next     = '0;
                    match_fnd_next  = 1'b0;
                    free_fnd_next   = 1'b0;
                    reject_next     = 1'b0;
                    scan_ctrl.clear = 1'b1;
                    state_next      = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (rd_idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                if (op_reg == OP_INSERT && !match_fnd_reg)
                begin
                    if (free_fnd_reg)
                    begin
                        ram_we                  = 1'b1;
                        used_next[free_idx_reg] = 1'b1;
                        count_next              = count_reg + 1'b1;
                    end
                    else
                    begin
                        reject_next = 1'b1;
                    end
                end
                else if (op_reg == OP_REMOVE && match_fnd_reg)
                begin
                    used_next[match_idx_reg] = 1'b0;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                scan_ctrl.step     = 1'b1;
                scan_ctrl.elem_vld = keep_val;
                scan_ctrl.excl_eq  = 1'b0;
                state_next         = ST_RESP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            proc_vld_reg  <= 1'b0;
            match_fnd_reg <= 1'b0;
            free_fnd_reg  <= 1'b0;
            reject_reg    <= 1'b0;
            used_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            proc_vld_reg  <= proc_vld_next;
            match_fnd_reg <= match_fnd_next;
            free_fnd_reg  <= free_fnd_next;
            reject_reg    <= reject_next;
            used_reg      <= used_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        proc_idx_reg  <= proc_idx_next;
        op_reg        <= op_next;
        val_reg       <= val_next;
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
    end

    ist_slot_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_W)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_idx_reg),
        .wdata (val_reg),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    ist_scan_unit u_scan_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (scan_ctrl),
        .elem  (scan_elem),
        .key   (val_reg),
        .eq    (scan_eq),
        .any   (scan_any),
        .lo    (scan_lo),
        .hi    (scan_hi)
    );

    // The result is held in registers and shown during the response cycle.
    assign busy        = !(state_reg == ST_IDLE || state_reg == ST_RESP);
    assign done        = (state_reg == ST_RESP);
    assign hit         = match_fnd_reg;
    assign full_reject = reject_reg;
    assign count       = count_reg;
    assign is_empty    = (count_reg == '0);
    assign min_value   = scan_any ? scan_lo : '0;
    assign max_value   = scan_any ? scan_hi : '0;

`ifndef SYNTHESIS
    // The count always equals the number of occupied slots.
    a_count_matches_used: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg) == count_reg)
        else $error("element count differs from occupancy bits");

    // A dropped insert is only possible with every slot occupied.
    a_reject_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && full_reject) |-> (count_reg == COUNT_W'(CAPACITY)))
        else $error("insert rejected while a slot was free");

    // A non-empty set reports an ordered minimum and maximum.
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !is_empty) |-> (min_value <= max_value))
        else $error("minimum above maximum");

    // The empty flag and the minimum/maximum reduction agree.
    a_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_empty == !scan_any))
        else $error("empty flag disagrees with min/max state");

    // The done strobe lasts exactly one cycle.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");
`endif

endmodule

/* tb/sv/tb_integer_set_table_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_set_table_top
// Self-checking bench for the integer set table. A queue of insert, remove
// and membership transactions is issued in bursts with random gaps. A set
// model in the bench predicts hit, reject, count, empty, minimum and maximum
// per transaction, and every done strobe is checked against it in order.
// ----------------------------------------------------------------------------
module tb_integer_set_table_top;

    import ist_pkg::*;

    // Membership test and the spare code, which the block treats as a test.
    localparam logic [OP_W-1:0] OP_TEST  = 2'd2;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam int RANDOM_CMDS  = 1850;
    localparam int POOL_SIZE    = 24;
    localparam int DRAIN_CYCLES = 30;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
    } set_cmd_t;

    typedef struct packed {
        logic                     hit;
        logic                     full_reject;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
        logic signed [DATA_W-1:0] min_value;
        logic signed [DATA_W-1:0] max_value;
    } set_status_t;

    // Every block input starts at a known value.
    logic                     clk   = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [OP_W-1:0]          op    = '0;
    logic signed [DATA_W-1:0] value = '0;

    logic                     busy;
    logic                     done;
    logic                     hit;
    logic                     full_reject;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
    logic signed [DATA_W-1:0] min_value;
    logic signed [DATA_W-1:0] max_value;

    integer_set_table_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .value       (value),
        .done        (done),
        .hit         (hit),
        .full_reject (full_reject),
        .count       (count),
        .is_empty    (is_empty),
        .min_value   (min_value),
        .max_value   (max_value)
    );

    // Transactions waiting to be issued, and the status words that the
    // accepted transactions are expected to return, oldest first.
    set_cmd_t    pending_cmds[$];
    set_status_t expected_status[$];
    int          fail_count = 0;

    // Shadow copy of the set: slot contents, occupancy and element count.
    logic signed [DATA_W-1:0] shadow_vals [CAPACITY];
    logic                     shadow_used [CAPACITY];
    int                       shadow_size;

    // Value pool for the random part; small enough that values repeat and
    // the store both fills up and drains, larger than the store so that
    // inserts into a full set occur.
    logic signed [DATA_W-1:0] value_pool [POOL_SIZE];

    // ------------------------------------------------------------------------
    // Clock and reset. Reset is held at the start and released on a rising
    // edge; it is never asserted again.
    // ------------------------------------------------------------------------
    always #10 clk = ~clk;

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Set model. Applies one operation to the shadow set and returns the
    // status word the block should report for it. The value goes to the
    // lowest free slot, and minimum and maximum are taken over the occupied
    // slots after the update, reading 0 when the set is empty.
    // ------------------------------------------------------------------------
    function automatic set_status_t apply_set_op(input logic [OP_W-1:0] opc,
                                                 input logic signed [DATA_W-1:0] v);
        set_status_t st;
        int          match_slot;
        int          free_slot;
        logic        seen;
        match_slot = -1;
        free_slot  = -1;
        seen       = 1'b0;
        st         = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (shadow_used[i])
            begin
                if (shadow_vals[i] == v && match_slot < 0)
                    match_slot = i;
            end
            else if (free_slot < 0)
                free_slot = i;
        end
        st.hit = (match_slot >= 0);

        if (opc == OP_INSERT && !st.hit)
        begin
            if (free_slot >= 0)
            begin
                shadow_vals[free_slot] = v;
                shadow_used[free_slot] = 1'b1;
                shadow_size++;
            end
            else
                st.full_reject = 1'b1;
        end
        else if (opc == OP_REMOVE && st.hit)
        begin
            shadow_used[match_slot] = 1'b0;
            shadow_size--;
        end

        for (int i = 0; i < CAPACITY; i++)
        begin
            if (shadow_used[i])
            begin
                if (!seen || shadow_vals[i] < st.min_value)
                    st.min_value = shadow_vals[i];
                if (!seen || shadow_vals[i] > st.max_value)
                    st.max_value = shadow_vals[i];
                seen = 1'b1;
            end
        end
        st.count    = shadow_size[COUNT_W-1:0];
        st.is_empty = (shadow_size == 0);
        return st;
    endfunction

    // ------------------------------------------------------------------------
    // Driver. A transaction is accepted at an edge where start is high and
    // busy is low; its expected status is computed right there, so the model
    // sees transactions in exactly the order the block does. The sender works
    // in bursts: within a burst start goes high again at once (and is simply
    // held while busy), after a burst it stays low for a random gap, which
    // may end anywhere within the block's scan of the slots.
    // ------------------------------------------------------------------------
    int       burst_left = 1;
    int       gap_left   = 0;
    set_cmd_t next_cmd;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            for (int i = 0; i < CAPACITY; i++)
                shadow_used[i] = 1'b0;
            shadow_size = 0;
        end
        else
        begin
            if (start && !busy)
                expected_status.insert(expected_status.size(), apply_set_op(op, value));

            if (start && busy)
            begin
                // Transaction still waiting for acceptance; hold it.
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                next_cmd = pending_cmds.pop_front();
                start <= 1'b1;
                op    <= next_cmd.op;
                value <= next_cmd.value;
                burst_left--;
                if (burst_left <= 0)
                begin
                    // Mostly short bursts; now and then a long unbroken run.
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 6);
                    gap_left   = $urandom_range(0, 40);
                end
            end
            else
                start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. done marks a result for exactly one cycle; it is taken at the
    // edge that ends that cycle and compared field by field with the oldest
    // expectation.
    // ------------------------------------------------------------------------
    task automatic compare_field(input string name, input longint want_v,
                                 input longint got_v);
        if (want_v != got_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        set_status_t want;
        if (rst_n && done)
        begin
            if (expected_status.size() == 0)
            begin
                $error("result with no transaction outstanding");
                fail_count++;
            end
            else
            begin
                want = expected_status.pop_front();
                compare_field("hit", want.hit, hit);
                compare_field("full_reject", want.full_reject, full_reject);
                compare_field("count", want.count, count);
                compare_field("is_empty", want.is_empty, is_empty);
                compare_field("min_value", want.min_value, min_value);
                compare_field("max_value", want.max_value, max_value);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus. Directed transactions come first, then random ones built as
    // phases that mostly fill or mostly drain the set over a shared pool of
    // values, so the store regularly runs full and runs empty.
    // ------------------------------------------------------------------------
    task automatic queue_cmd(input logic [OP_W-1:0] opc,
                             input logic signed [DATA_W-1:0] v);
        set_cmd_t c;
        c.op    = opc;
        c.value = v;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    function automatic logic signed [DATA_W-1:0] pool_entry();
        case ($urandom_range(0, 3))
            0:       return $signed($urandom_range(0, 16)) - 8;
            1:       return 32'sh8000_0000 + $urandom_range(0, 3);
            2:       return 32'sh7fff_ffff - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin : stimulus
        int               phase_len;
        int               insert_pct;
        int               remove_pct;
        int               roll;
        logic [OP_W-1:0]  opc;
        logic signed [DATA_W-1:0] v;

        // Empty set: membership and remove of an absent value, both reading
        // zero minimum and maximum with the empty flag set.
        queue_cmd(OP_TEST, 32'sd0);
        queue_cmd(OP_REMOVE, 32'sd5);
        // The extremes of the value range, a duplicate insert, and the
        // spare code acting as a membership test.
        queue_cmd(OP_INSERT, 32'sh7fff_ffff);
        queue_cmd(OP_INSERT, 32'sh8000_0000);
        queue_cmd(OP_INSERT, 32'sh7fff_ffff);
        queue_cmd(OP_SPARE, 32'sh8000_0000);
        queue_cmd(OP_REMOVE, 32'sh8000_0000);
        // Fill every slot, including zero and minus one, then insert an
        // absent value into the full store and re-insert a present one.
        queue_cmd(OP_INSERT, 32'sd0);
        queue_cmd(OP_INSERT, -32'sd1);
        for (int i = 1; i <= 13; i++)
            queue_cmd(OP_INSERT, (i % 2) ? -i * 32'sd1000003 : i * 32'sd77777);
        queue_cmd(OP_INSERT, 32'sd12345);
        queue_cmd(OP_INSERT, -32'sd1);

        for (int i = 0; i < POOL_SIZE; i++)
            value_pool[i] = pool_entry();

        while (pending_cmds.size() < RANDOM_CMDS + 24)
        begin
            phase_len = $urandom_range(10, 60);
            case ($urandom_range(0, 2))
                0:       begin insert_pct = 65; remove_pct = 20; end
                1:       begin insert_pct = 20; remove_pct = 65; end
                default: begin insert_pct = 40; remove_pct = 40; end
            endcase
            for (int k = 0; k < 3; k++)
                value_pool[$urandom_range(0, POOL_SIZE - 1)] = pool_entry();

            for (int n = 0; n < phase_len; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < insert_pct)
                    opc = OP_INSERT;
                else if (roll < insert_pct + remove_pct)
                    opc = OP_REMOVE;
                else
                    opc = ($urandom_range(0, 3) == 0) ? OP_SPARE : OP_TEST;
                v = ($urandom_range(0, 9) == 0) ? $signed($urandom)
                                                : value_pool[$urandom_range(0, POOL_SIZE - 1)];
                queue_cmd(opc, v);
            end
        end

        // Wait for the last transaction to be accepted, then for its result.
        while (pending_cmds.size() != 0 || start)
            @(posedge clk);
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of about 1.6 ms.
    initial
    begin
        #12_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
